// ===== src/quaternion_arith_unit_macros.svh =====
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef QUATERNION_ARITH_UNIT_MACROS_SVH
`define QUATERNION_ARITH_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define QAU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QAU_ASSERT_IMPL(lbl, ante, cons, msg)
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/qau_pkg.sv =====
package qau_pkg;

	localparam int CW   = 32;
	localparam int FB   = 16;
	localparam int FN_W = 3;
	localparam int ST_W = 2;

	localparam int IN_TDW  = 8 * CW;
	localparam int OUT_TDW = 4 * CW;

	localparam int PW   = 2 * CW;
	localparam int SW   = PW + 1;
	localparam int NUMW = PW + 2;
	localparam int NW   = SW + FB;
	localparam int QW   = CW;
	localparam int DW   = SW;
	localparam int RW   = DW + 1;
	localparam int XW   = ((SW + 2 * FB + 1) / 2) * 2;
	localparam int RTW  = XW / 2;
	localparam int SRW  = RTW + 3;

	localparam int SQ_ST = RTW;
	localparam int DV_ST = QW;

	localparam logic [FN_W-1:0] FN_MAG_SQ = 3'd0;
	localparam logic [FN_W-1:0] FN_MAG    = 3'd1;
	localparam logic [FN_W-1:0] FN_NORM   = 3'd2;
	localparam logic [FN_W-1:0] FN_CONJ   = 3'd3;
	localparam logic [FN_W-1:0] FN_INV    = 3'd4;
	localparam logic [FN_W-1:0] FN_DIV    = 3'd5;

	localparam logic [ST_W-1:0] ST_OK  = 2'd0;
	localparam logic [ST_W-1:0] ST_SAT = 2'd1;
	localparam logic [ST_W-1:0] ST_DZ  = 2'd2;

	localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};

	// Terms of a * conj(b): for result k and term i, the a index, the b index and
	// whether the product is subtracted.
	localparam logic [1:0] DT_A [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2}};
	localparam logic [1:0] DT_B [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd3, 2'd0, 2'd2, 2'd1}};
	localparam logic DT_SUB [4][4] = '{'{1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b1, 1'b0}};

	typedef struct packed {
		logic [FN_W-1:0]        func;
		logic                   zero;
		logic [3:0]             neg;
		logic [3:0][NW-1:0]     num;
		logic [DW-1:0]          dsel;
		logic [3:0][CW-1:0]     r;
		logic                   sat;
	} side_t;

	typedef struct packed {
		logic [SRW-1:0] rem;
		logic [RTW-1:0] root;
		logic [XW-1:0]  x;
	} sq_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [QW-1:0] quo;
		logic [QW-1:0] nlo;
		logic          ovf;
	} dl_t;

	typedef struct packed {
		dl_t [3:0]     lane;
		logic [DW-1:0] d;
	} dvs_t;

	// One digit of the restoring square root.
	function automatic sq_t sq_step(sq_t c);
		logic [SRW-1:0] sh;
		logic [SRW-1:0] trial;
		sq_t n;
		sh = {c.rem[SRW-3:0], c.x[XW-1 -: 2]};
		trial = {1'b0, c.root, 2'b01};
		n.x = {c.x[XW-3:0], 2'b00};
		if (sh >= trial) begin
			n.rem = sh - trial;
			n.root = {c.root[RTW-2:0], 1'b1};
		end else begin
			n.rem = sh;
			n.root = {c.root[RTW-2:0], 1'b0};
		end
		return n;
	endfunction

	// One quotient bit of the restoring divider.
	function automatic dl_t dv_step(dl_t c, logic [DW-1:0] d);
		logic [RW-1:0] sh;
		dl_t n;
		sh = {c.rem[RW-2:0], c.nlo[QW-1]};
		n.nlo = {c.nlo[QW-2:0], 1'b0};
		n.ovf = c.ovf;
		if (sh >= {1'b0, d}) begin
			n.rem = sh - {1'b0, d};
			n.quo = {c.quo[QW-2:0], 1'b1};
		end else begin
			n.rem = sh;
			n.quo = {c.quo[QW-2:0], 1'b0};
		end
		return n;
	endfunction

	// Sign and magnitude to a saturated component; the top bit flags saturation.
	function automatic logic [CW:0] q_emit(logic neg, logic [QW-1:0] q, logic ovf);
		logic [CW:0] res;
		if (!neg) begin
			if (ovf || q[CW-1]) res = {1'b1, MAXP};
			else res = {1'b0, q};
		end else begin
			if (ovf || (q[CW-1] && (|q[CW-2:0]))) res = {1'b1, MINN};
			else res = {1'b0, CW'(-q)};
		end
		return res;
	endfunction

endpackage

// ===== src/quaternion_arith_unit.sv =====
// Quaternion arithmetic on Q16.16 components: squared magnitude, magnitude,
// normalize, conjugate, inverse and divide, selected per request by s_tuser.
// A new request is taken every clock unless the pipeline holds. Each request
// passes through the 49-step square root followed by four 32-step restoring
// dividers, one digit per stage. When the output register is full and not
// taken, the whole pipeline holds.
`include "quaternion_arith_unit_macros.svh"

module quaternion_arith_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
	input  logic [qau_pkg::IN_TDW-1:0]      s_tdata,
	// func
	input  logic [qau_pkg::FN_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// r_w, r_x, r_y, r_z
	output logic [qau_pkg::OUT_TDW-1:0]     m_tdata,
	// status
	output logic [qau_pkg::ST_W-1:0]        m_tuser
);
	import qau_pkg::*;

	logic en;

	logic signed [CW-1:0] a_in [4];
	logic signed [CW-1:0] b_in [4];

	logic                 v_s1;
	logic [FN_W-1:0]      func_s1;
	logic signed [CW-1:0] a_s1 [4];
	logic [PW-1:0]        asq_s1 [4];
	logic [PW-1:0]        bsq_s1 [4];
	logic signed [PW-1:0] ab_s1 [4][4];

	side_t          side2_c;
	logic [XW-1:0]  x2_c;

	sq_t   sq_s  [0:SQ_ST];
	side_t sqd_s [0:SQ_ST];
	logic  sqv_s [0:SQ_ST];

	dvs_t  dv0_c;
	side_t dvd0_c;

	dvs_t  dv_s  [0:DV_ST];
	side_t dvd_s [0:DV_ST];
	logic  dvv_s [0:DV_ST];

	logic [OUT_TDW-1:0] rdata_c;
	logic [ST_W-1:0]    rstat_c;

	logic                m_tvalid_q;
	logic [OUT_TDW-1:0]  m_tdata_q;
	logic [ST_W-1:0]     m_tuser_q;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a_in[i] = s_tdata[i*CW +: CW];
			b_in[i] = s_tdata[(4+i)*CW +: CW];
		end
	end

	// Stage 1: every square and cross product.
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= s_tuser;
			for (int i = 0; i < 4; i++) begin
				a_s1[i]   <= a_in[i];
				asq_s1[i] <= PW'($signed(a_in[i]) * $signed(a_in[i]));
				bsq_s1[i] <= PW'($signed(b_in[i]) * $signed(b_in[i]));
				for (int j = 0; j < 4; j++)
					ab_s1[i][j] <= $signed(a_in[i]) * $signed(b_in[j]);
			end
		end
	end

	// Stage 2: sums, numerators and the results that need no root or quotient.
	always_comb begin
		logic [SW-1:0]          s_v;
		logic [SW-1:0]          t_v;
		logic signed [NUMW-1:0] acc;
		logic [SW-1:0]          nmag;
		logic [CW-1:0]          amag;
		logic [SW-FB-1:0]       msq;
		s_v = '0;
		t_v = '0;
		for (int i = 0; i < 4; i++) begin
			s_v = s_v + SW'(asq_s1[i]);
			t_v = t_v + SW'(bsq_s1[i]);
		end
		side2_c = '0;
		side2_c.func = func_s1;
		side2_c.zero = (func_s1 == FN_DIV) ? (t_v == '0) : (s_v == '0);
		side2_c.dsel = (func_s1 == FN_INV) ? s_v : t_v;
		for (int k = 0; k < 4; k++) begin
			acc = '0;
			for (int i = 0; i < 4; i++) begin
				if (DT_SUB[k][i])
					acc = acc - NUMW'(ab_s1[DT_A[k][i]][DT_B[k][i]]);
				else
					acc = acc + NUMW'(ab_s1[DT_A[k][i]][DT_B[k][i]]);
			end
			nmag = acc[NUMW-1] ? SW'(-acc) : SW'(acc);
			amag = a_s1[k][CW-1] ? CW'(-a_s1[k]) : CW'(a_s1[k]);
			if (func_s1 == FN_DIV) begin
				side2_c.num[k] = {nmag, {FB{1'b0}}};
				side2_c.neg[k] = acc[NUMW-1];
			end else begin
				side2_c.num[k] = NW'({amag, {(2*FB){1'b0}}});
				side2_c.neg[k] = (func_s1 == FN_INV && k != 0) ? !a_s1[k][CW-1]
					: a_s1[k][CW-1];
			end
		end
		msq = s_v[SW-1:FB];
		if (func_s1 == FN_MAG_SQ) begin
			if (|msq[SW-FB-1:CW-1]) begin
				side2_c.r[0] = MAXP;
				side2_c.sat = 1'b1;
			end else begin
				side2_c.r[0] = msq[CW-1:0];
			end
		end else if (func_s1 == FN_CONJ) begin
			side2_c.r[0] = a_s1[0];
			for (int i = 1; i < 4; i++) begin
				if (a_s1[i] == MINN) begin
					side2_c.r[i] = MAXP;
					side2_c.sat = 1'b1;
				end else begin
					side2_c.r[i] = CW'(-a_s1[i]);
				end
			end
		end
		x2_c = (func_s1 == FN_NORM) ? XW'({s_v, {(2*FB){1'b0}}}) : XW'(s_v);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0]  <= '{rem: '0, root: '0, x: x2_c};
			sqd_s[0] <= side2_c;
			for (int i = 1; i <= SQ_ST; i++) begin
				sq_s[i]  <= sq_step(sq_s[i-1]);
				sqd_s[i] <= sqd_s[i-1];
			end
		end
	end

	// Divider entry: pick the divisor, check whether the quotient fits and finish the magnitude result.
	always_comb begin
		logic [RTW-1:0] root;
		logic [NW-QW-1:0] nh;
		root = sq_s[SQ_ST].root;
		dvd0_c = sqd_s[SQ_ST];
		dv0_c.d = (dvd0_c.func == FN_NORM) ? DW'(root) : dvd0_c.dsel;
		for (int k = 0; k < 4; k++) begin
			nh = dvd0_c.num[k][NW-1:QW];
			dv0_c.lane[k].rem = RW'(nh);
			dv0_c.lane[k].quo = '0;
			dv0_c.lane[k].nlo = dvd0_c.num[k][QW-1:0];
			dv0_c.lane[k].ovf = RW'(nh) >= RW'(dv0_c.d);
		end
		if (dvd0_c.func == FN_MAG) begin
			if (|root[RTW-1:CW-1]) begin
				dvd0_c.r[0] = MAXP;
				dvd0_c.sat = 1'b1;
			end else begin
				dvd0_c.r[0] = root[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0]  <= dv0_c;
			dvd_s[0] <= dvd0_c;
			for (int i = 1; i <= DV_ST; i++) begin
				dv_s[i].d <= dv_s[i-1].d;
				for (int k = 0; k < 4; k++)
					dv_s[i].lane[k] <= dv_step(dv_s[i-1].lane[k], dv_s[i-1].d);
				dvd_s[i] <= dvd_s[i-1];
			end
		end
	end

	always_comb begin
		logic [CW:0] e;
		logic        sat;
		rdata_c = '0;
		rstat_c = ST_OK;
		sat = 1'b0;
		unique case (dvd_s[DV_ST].func) inside
			FN_NORM, FN_INV, FN_DIV: begin
				if (dvd_s[DV_ST].zero) begin
					rstat_c = ST_DZ;
				end else begin
					for (int k = 0; k < 4; k++) begin
						e = q_emit(dvd_s[DV_ST].neg[k], dv_s[DV_ST].lane[k].quo,
							dv_s[DV_ST].lane[k].ovf);
						rdata_c[k*CW +: CW] = e[CW-1:0];
						sat = sat | e[CW];
					end
					rstat_c = sat ? ST_SAT : ST_OK;
				end
			end
			default: begin
				for (int k = 0; k < 4; k++)
					rdata_c[k*CW +: CW] = dvd_s[DV_ST].r[k];
				rstat_c = dvd_s[DV_ST].sat ? ST_SAT : ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= rdata_c;
			m_tuser_q <= rstat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i <= SQ_ST; i++) sqv_s[i] <= 1'b0;
			for (int i = 0; i <= DV_ST; i++) dvv_s[i] <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			sqv_s[0] <= v_s1;
			for (int i = 1; i <= SQ_ST; i++) sqv_s[i] <= sqv_s[i-1];
			dvv_s[0] <= sqv_s[SQ_ST];
			for (int i = 1; i <= DV_ST; i++) dvv_s[i] <= dvv_s[i-1];
			m_tvalid_q <= dvv_s[DV_ST];
		end
	end

	`QAU_ASSERT_IMPL(a_dz_zero, m_tvalid && (m_tuser == ST_DZ), m_tdata == '0, "divide by zero with nonzero result")
	`QAU_ASSERT_IMPL(a_stat_legal, m_tvalid, (m_tuser == ST_OK) || (m_tuser == ST_SAT) || (m_tuser == ST_DZ), "undefined status code")
	`QAU_ASSERT_NEXT(a_stall_hold, !en, $stable(v_s1) && $stable(dvv_s[DV_ST]), "pipeline moved during a stall")
	`QAU_ASSERT_IMPL(a_sqrt_rem, sqv_s[SQ_ST], sq_s[SQ_ST].rem <= SRW'({sq_s[SQ_ST].root, 1'b0}), "square root remainder out of range")
	`QAU_ASSERT_IMPL(a_div_rem, dvv_s[DV_ST] && !dv_s[DV_ST].lane[0].ovf && (dv_s[DV_ST].d != '0), dv_s[DV_ST].lane[0].rem < RW'(dv_s[DV_ST].d), "divider remainder not below divisor")

endmodule
